// ----- hdl/feal8_pkg.sv -----
// Shared types, constants and round functions for the FEAL-8 block decryptor.
`timescale 1ns / 1ps
package feal8_pkg;

  localparam int BLOCK_W      = 64;
  localparam int KEY_W        = 64;
  localparam int CFG_IDX_W    = 1;
  localparam int SUBKEY_BYTES = 32;
  localparam int KS_PASSES    = 8;
  localparam int PASS_W       = $clog2(KS_PASSES);

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY    = 1'b0,
    REG_BYPASS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              busy;
    logic [PASS_W-1:0] pass;
  } ks_status_t;

  // byte add with optional carry-in, then rotate left by 2
  function automatic byte_t sbox(input byte_t a, input byte_t b, input logic c);
    byte_t s;
    s = a + b + {7'd0, c};
    return {s[5:0], s[7:6]};
  endfunction

  function automatic logic [BLOCK_W-1:0] feal_round(input logic [BLOCK_W-1:0] d,
                                                    input byte_t ka, input byte_t kb);
    byte_t n4, n5, n6, n7;
    n5 = d[47:40] ^ d[39:32] ^ ka;
    n6 = d[55:48] ^ d[63:56] ^ kb;
    n5 = sbox(n5, n6, 1'b1);
    n6 = sbox(n5, n6, 1'b0);
    n4 = sbox(d[39:32], n5, 1'b0);
    n7 = sbox(d[63:56], n6, 1'b1);
    return {n7 ^ d[31:24], n6 ^ d[23:16], n5 ^ d[15:8], n4 ^ d[7:0], d[63:32]};
  endfunction

  function automatic logic [BLOCK_W-1:0] whiten_in(input logic [BLOCK_W-1:0] blk,
                                                   input logic [BLOCK_W-1:0] k);
    logic [BLOCK_W-1:0] x;
    x = blk ^ k;
    return {x[63:32] ^ x[31:0], x[31:0]};
  endfunction

  function automatic logic [BLOCK_W-1:0] whiten_out(input logic [BLOCK_W-1:0] d,
                                                    input logic [BLOCK_W-1:0] k);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = d[63:32] ^ d[31:0];
    lo = d[31:0] ^ hi;
    return {hi, lo} ^ k;
  endfunction

endpackage

// ----- hdl/feal8_keysched.sv -----
// Key schedule sequencer: one pass per cycle, four subkey bytes per pass.
`timescale 1ns / 1ps
module feal8_keysched import feal8_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_load,
  input  logic [KEY_W-1:0] key,
  output ks_status_t       status,
  output byte_t            subkey [SUBKEY_BYTES]
);

  byte_t             v [8];
  byte_t             prev [4];
  logic              busy;
  logic [PASS_W-1:0] pass;

  byte_t             v_next [8];
  byte_t             prev_next [4];

  always_comb begin
    byte_t mix [4];
    byte_t t4, t5, t6, t7;
    for (int i = 0; i < 4; i++) begin
      mix[i]       = v[i+4] ^ prev[i];
      prev_next[i] = v[i];
      v_next[i]    = v[i+4];
    end
    t5 = v[1] ^ v[0];
    t6 = v[3] ^ v[2];
    t5 = sbox(t5, t6 ^ mix[0], 1'b1);
    t6 = sbox(t6, t5 ^ mix[1], 1'b0);
    t4 = sbox(v[0], t5 ^ mix[2], 1'b0);
    t7 = sbox(v[3], t6 ^ mix[3], 1'b1);
    v_next[4] = t4;
    v_next[5] = t5;
    v_next[6] = t6;
    v_next[7] = t7;
  end

  // reset runs the schedule of the all-zero key
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      pass <= '0;
      for (int i = 0; i < 8; i++) v[i] <= '0;
      for (int i = 0; i < 4; i++) prev[i] <= '0;
    end else if (key_load) begin
      busy <= 1'b1;
      pass <= '0;
      for (int i = 0; i < 8; i++) v[i] <= key[8*i +: 8];
      for (int i = 0; i < 4; i++) prev[i] <= '0;
    end else if (busy) begin
      pass <= pass + 1'b1;
      if (pass == PASS_W'(KS_PASSES - 1)) busy <= 1'b0;
      v    <= v_next;
      prev <= prev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !key_load) begin
      for (int i = 0; i < 4; i++) subkey[{pass, 2'(i)}] <= v_next[i+4];
    end
  end

  assign status.busy = busy;
  assign status.pass = pass;

endmodule

// ----- hdl/feal8_block_decrypt.sv -----
// Top level: four-stage FEAL-8 decryption pipeline with stream ports.
`timescale 1ns / 1ps
// Decrypts one 64-bit block per cycle unless backpressure or the key schedule
// holds it; two Feistel rounds sit in each of the four pipeline stages, input
// whitening in the first and output whitening in the last, and the last stage
// is the output register. Backpressure propagates stage by stage, so bubbles
// fill while the output waits. After reset and after every key write the
// subkey sequencer runs eight passes, one per cycle, and s_axis_tready stays
// low until they are done. With bypass set, words pass through unchanged.
module feal8_block_decrypt import feal8_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BLOCK_W-1:0]   s_axis_tdata,   // cipher_block
  input  logic                 s_axis_tlast,   // last_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BLOCK_W-1:0]   m_axis_tdata,   // plain_block
  output logic                 m_axis_tlast,   // last_out
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata
);

  localparam int STAGES = 4;

  ks_status_t         ks;
  byte_t              subkey [SUBKEY_BYTES];
  logic               bypass;
  logic               key_load;

  logic [BLOCK_W-1:0] k_in;
  logic [BLOCK_W-1:0] k_out;

  logic [STAGES-1:0]  vld;
  logic [STAGES-1:0]  rdy;
  logic [BLOCK_W-1:0] dat [STAGES];
  logic               lst [STAGES];
  logic [BLOCK_W-1:0] dat_next [STAGES];
  logic               in_acc;

  assign key_load = cfg_we && (cfg_index == REG_KEY);

  feal8_keysched u_ks (
    .clk      (clk),
    .rst      (rst),
    .key_load (key_load),
    .key      (cfg_wdata),
    .status   (ks),
    .subkey   (subkey)
  );

  always_ff @(posedge clk) begin
    if (rst) bypass <= 1'b0;
    else if (cfg_we && (cfg_index == REG_BYPASS)) bypass <= cfg_wdata[0];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      k_in[8*i +: 8]  = subkey[24 + i];
      k_out[8*i +: 8] = subkey[16 + i];
    end
  end

  // user must change bypass only while the pipeline is empty; not enforced
  always_comb begin
    dat_next[0] = bypass ? s_axis_tdata :
        feal_round(feal_round(whiten_in(s_axis_tdata, k_in), subkey[14], subkey[15]),
                   subkey[12], subkey[13]);
    dat_next[1] = bypass ? dat[0] :
        feal_round(feal_round(dat[0], subkey[10], subkey[11]), subkey[8], subkey[9]);
    dat_next[2] = bypass ? dat[1] :
        feal_round(feal_round(dat[1], subkey[6], subkey[7]), subkey[4], subkey[5]);
    dat_next[3] = bypass ? dat[2] :
        whiten_out(feal_round(feal_round(dat[2], subkey[2], subkey[3]),
                              subkey[0], subkey[1]), k_out);
  end

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) rdy[k] = !vld[k] || rdy[k+1];
  end

  assign s_axis_tready = rdy[0] && !ks.busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_acc;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dat[0] <= dat_next[0];
      lst[0] <= s_axis_tlast;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) begin
        dat[k] <= dat_next[k];
        lst[k] <= lst[k-1];
      end
    end
  end

  assign m_axis_tvalid = vld[STAGES-1];
  assign m_axis_tdata  = dat[STAGES-1];
  assign m_axis_tlast  = lst[STAGES-1];

`ifndef NO_ASSERTIONS
  // a key write holds off input while the new subkeys are built
  a_key_blocks_input: assert property (@(posedge clk)
    cfg_we && (cfg_index == REG_KEY) |=> !s_axis_tready)
    else $error("input accepted right after a key write");

  // schedule ends only after its final pass
  a_ks_full_run: assert property (@(posedge clk) disable iff (rst)
    $fell(ks.busy) |-> ($past(ks.pass) == PASS_W'(KS_PASSES - 1)))
    else $error("key schedule ended early");

  // a word in the third stage moves into the output register when it is free
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-2] && rdy[STAGES-1] |=> m_axis_tvalid)
    else $error("word lost between the last two stages");
`endif

endmodule
